// ----- hdl/eots_pkg.sv -----
// Shared types, codes and constants of the EDNS option TLV scanner.
`default_nettype none

package eots_pkg;

    localparam int HEADER_BYTES   = 4;
    localparam int RES_FIFO_DEPTH = 4;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_CODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_ALL   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_INDEX = 8'd3;

    // Input actions.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // Result kinds.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Final status codes.
    localparam logic [1:0] ST_SUCCESS    = 2'd0;
    localparam logic [1:0] ST_MORE       = 2'd1;
    localparam logic [1:0] ST_UNEXPECTED = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_VALUE  = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [15:0] match_code;
        logic        match_all;
        logic [7:0]  capacity;
        logic [13:0] start_index;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [15:0] option_code;
        logic [15:0] option_length;
        logic [15:0] value_offset;
        logic [13:0] option_index;
        logic [13:0] resume_index;
        logic [7:0]  found_count;
        logic        last;
    } res_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] push_n;
    } core_stat_t;

endpackage

`default_nettype wire

// ----- hdl/eots_ifs.sv -----
// Channel interfaces of the EDNS option TLV scanner: input items, results, configuration.
`default_nettype none

interface eots_item_if import eots_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] record_length;
    logic [7:0]  data_byte;

    modport source (output valid, action, record_length, data_byte, input ready);
    modport sink   (input valid, action, record_length, data_byte, output ready);
endinterface

interface eots_result_if import eots_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [15:0] option_code;
    logic [15:0] option_length;
    logic [15:0] value_offset;
    logic [13:0] option_index;
    logic [13:0] resume_index;
    logic [7:0]  found_count;
    logic        last;

    modport source (output valid, kind, status, option_code, option_length, value_offset,
                    option_index, resume_index, found_count, last, input ready);
    modport sink   (input valid, kind, status, option_code, option_length, value_offset,
                    option_index, resume_index, found_count, last, output ready);
endinterface

interface eots_cfg_if import eots_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/eots_cfg.sv -----
// Configuration registers of the EDNS option TLV scanner.
`default_nettype none

module eots_cfg import eots_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_code  <= '0;
            cfg_reg.match_all   <= 1'b0;
            cfg_reg.capacity    <= 8'd1;
            cfg_reg.start_index <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_MATCH_CODE:  cfg_reg.match_code  <= wr_data;
                CFG_MATCH_ALL:   cfg_reg.match_all   <= wr_data[0];
                CFG_CAPACITY:    cfg_reg.capacity    <= wr_data[7:0];
                CFG_START_INDEX: cfg_reg.start_index <= wr_data[13:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/eots_core.sv -----
// Scan state and per-byte decision logic; produces up to two results per accepted item.
`default_nettype none

module eots_core import eots_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic        action,
    input  wire logic [15:0] record_length,
    input  wire logic [7:0]  data_byte,
    input  wire cfg_t        cfg,
    output res_t             res0,
    output res_t             res1,
    output core_stat_t       stat
);

    phase_t      phase_reg,          phase_next;
    logic [1:0]  header_count_reg,   header_count_next;
    logic [15:0] code_reg,           code_next;
    logic [15:0] length_reg,         length_next;
    logic [15:0] bytes_left_reg,     bytes_left_next;
    logic [15:0] value_left_reg,     value_left_next;
    logic [15:0] byte_position_reg,  byte_position_next;
    logic [13:0] option_counter_reg, option_counter_next;
    logic [7:0]  reported_count_reg, reported_count_next;

    logic [15:0] bl_dec;
    logic [15:0] vl_dec;
    logic [15:0] pos_inc;
    logic [15:0] code_shift;
    logic [15:0] len_shift;
    logic        hit;
    logic        rep_valid;
    logic        fin_valid;
    logic [1:0]  fin_status;
    logic [13:0] fin_resume;
    logic        do_bnd;
    logic [15:0] bnd_left;
    res_t        rep;
    res_t        fin;

    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        code_next           = code_reg;
        length_next         = length_reg;
        bytes_left_next     = bytes_left_reg;
        value_left_next     = value_left_reg;
        byte_position_next  = byte_position_reg;
        option_counter_next = option_counter_reg;
        reported_count_next = reported_count_reg;

        bl_dec     = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : bytes_left_reg;
        vl_dec     = (value_left_reg != 16'd0) ? value_left_reg - 16'd1 : value_left_reg;
        pos_inc    = byte_position_reg + 16'd1;
        code_shift = {code_reg[7:0], data_byte};
        len_shift  = {length_reg[7:0], data_byte};
        // The code is complete once the second header byte arrives.
        hit = ((code_reg == cfg.match_code) || cfg.match_all) &&
              (option_counter_reg >= cfg.start_index);

        rep_valid  = 1'b0;
        fin_valid  = 1'b0;
        fin_status = ST_SUCCESS;
        fin_resume = '0;
        do_bnd     = 1'b0;
        bnd_left   = '0;

        if (fire)
        begin
            if (action == ACT_START)
            begin
                bytes_left_next     = record_length;
                value_left_next     = '0;
                byte_position_next  = '0;
                option_counter_next = '0;
                reported_count_next = '0;
                do_bnd              = 1'b1;
                bnd_left            = record_length;
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        byte_position_next = pos_inc;
                        bytes_left_next    = bl_dec;
                        if (header_count_reg < 2'd2)
                        begin
                            code_next = code_shift;
                        end
                        else
                        begin
                            length_next = len_shift;
                        end
                        if (header_count_reg != 2'd3)
                        begin
                            header_count_next = header_count_reg + 2'd1;
                        end
                        else
                        begin
                            header_count_next = '0;
                            if (len_shift > bl_dec)
                            begin
                                fin_valid  = 1'b1;
                                fin_status = ST_UNEXPECTED;
                            end
                            else if (hit && (reported_count_reg >= cfg.capacity))
                            begin
                                fin_valid  = 1'b1;
                                fin_status = ST_MORE;
                                fin_resume = option_counter_reg;
                            end
                            else
                            begin
                                if (hit)
                                begin
                                    rep_valid           = 1'b1;
                                    reported_count_next = reported_count_reg + 8'd1;
                                end
                                if (len_shift == 16'd0)
                                begin
                                    option_counter_next = option_counter_reg + 14'd1;
                                    do_bnd              = 1'b1;
                                    bnd_left            = bl_dec;
                                end
                                else
                                begin
                                    value_left_next = len_shift;
                                    phase_next      = PH_VALUE;
                                end
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        byte_position_next = pos_inc;
                        bytes_left_next    = bl_dec;
                        value_left_next    = vl_dec;
                        if (vl_dec == 16'd0)
                        begin
                            option_counter_next = option_counter_reg + 14'd1;
                            do_bnd              = 1'b1;
                            bnd_left            = bl_dec;
                        end
                    end
                    default: ;
                endcase
            end

            // Option boundary: end of record, short tail, or the next header.
            if (do_bnd)
            begin
                if (bnd_left == 16'd0)
                begin
                    fin_valid  = 1'b1;
                    fin_status = ST_SUCCESS;
                end
                else if (bnd_left < 16'(HEADER_BYTES))
                begin
                    fin_valid  = 1'b1;
                    fin_status = ST_UNEXPECTED;
                end
                else
                begin
                    phase_next        = PH_HEADER;
                    header_count_next = '0;
                    code_next         = '0;
                    length_next       = '0;
                end
            end

            if (fin_valid)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    always_comb
    begin
        rep               = '0;
        rep.kind          = KIND_REPORT;
        rep.status        = ST_SUCCESS;
        rep.option_code   = code_reg;
        rep.option_length = len_shift;
        rep.value_offset  = pos_inc;
        rep.option_index  = option_counter_reg;
        rep.found_count   = reported_count_next;

        fin               = '0;
        fin.kind          = KIND_STATUS;
        fin.status        = fin_status;
        fin.resume_index  = fin_resume;
        fin.found_count   = reported_count_next;
        fin.last          = 1'b1;

        res0        = rep_valid ? rep : fin;
        res1        = fin;
        stat.phase  = phase_reg;
        stat.push_n = {1'b0, rep_valid} + {1'b0, fin_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            header_count_reg   <= '0;
            code_reg           <= '0;
            length_reg         <= '0;
            bytes_left_reg     <= '0;
            value_left_reg     <= '0;
            byte_position_reg  <= '0;
            option_counter_reg <= '0;
            reported_count_reg <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            code_reg           <= code_next;
            length_reg         <= length_next;
            bytes_left_reg     <= bytes_left_next;
            value_left_reg     <= value_left_next;
            byte_position_reg  <= byte_position_next;
            option_counter_reg <= option_counter_next;
            reported_count_reg <= reported_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/eots_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per transfer.
`default_nettype none

module eots_fifo import eots_pkg::*; #(
    parameter int DEPTH = RES_FIFO_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  push_n,
    input  wire res_t        push0,
    input  wire res_t        push1,
    output logic             room,
    output logic             out_valid,
    input  wire logic        out_ready,
    output res_t             out_data,
    output logic [CNT_W-1:0] fill
);

    res_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push_n == 2'd1)
        begin
            wr_ptr_next = wr_ptr_p1;
        end
        else if (push_n == 2'd2)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_p1);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // One item may bring two results, so keep two entries free before accepting.
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign fill      = count_reg;

endmodule

`default_nettype wire

// ----- hdl/edns_option_tlv_scanner_top.sv -----
// Top level of the EDNS option TLV scanner.
//
// The scanner walks one DNS OPT record a byte per item: a start item gives the
// record length, then each data item carries one record byte. It accepts one item
// per clock while the result queue has room; the scan state updates in the cycle
// of the transfer, and the results (none, one, or two for a matching zero-length
// option that also ends the record) enter a result queue of FIFO_DEPTH entries
// and are visible the next cycle. The input is ready whenever at least two queue
// entries are free, so with the result side always ready the block sustains one
// item per cycle; the result port moves one result per transfer, which sets the
// rate when items produce two results. Configuration writes are taken at any
// time, and are meant to be made while no scan is producing results.
`default_nettype none

module edns_option_tlv_scanner_top import eots_pkg::*; #(
    parameter int FIFO_DEPTH = RES_FIFO_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    eots_item_if.sink     item,
    eots_result_if.source result,
    eots_cfg_if.sink      cfg
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cfg_t             cfg_val;
    res_t             res0;
    res_t             res1;
    res_t             head;
    core_stat_t       core_stat;
    logic             room;
    logic             item_fire;
    logic [CNT_W-1:0] fill;

    assign cfg.ready  = 1'b1;
    assign item.ready = room;
    assign item_fire  = item.valid && room;

    eots_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    eots_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (item_fire),
        .action        (item.action),
        .record_length (item.record_length),
        .data_byte     (item.data_byte),
        .cfg           (cfg_val),
        .res0          (res0),
        .res1          (res1),
        .stat          (core_stat)
    );

    eots_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (core_stat.push_n),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (head),
        .fill      (fill)
    );

    assign result.kind          = head.kind;
    assign result.status        = head.status;
    assign result.option_code   = head.option_code;
    assign result.option_length = head.option_length;
    assign result.value_offset  = head.value_offset;
    assign result.option_index  = head.option_index;
    assign result.resume_index  = head.resume_index;
    assign result.found_count   = head.found_count;
    assign result.last          = head.last;

    // Bytes that arrive with no scan in progress produce nothing.
    a_idle_bytes_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && (item.action == ACT_DATA) &&
         ((core_stat.phase == PH_IDLE) || (core_stat.phase == PH_DONE)))
        |-> (core_stat.push_n == 2'd0))
        else $error("result produced for a byte outside a scan");

    // The queue never holds more than its depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // Results are only pushed for accepted items.
    a_push_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        (core_stat.push_n != 2'd0) |-> item_fire)
        else $error("result pushed without an input transfer");

    // A final status is always marked last; a report never is.
    a_last_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.last == result.kind) &&
                          ((result.kind == KIND_STATUS) || (result.status == ST_SUCCESS))))
        else $error("result kind and last flag disagree");

endmodule

`default_nettype wire

// ----- sim/edns_option_tlv_scanner_top_tb.sv -----
// Self-checking testbench of the EDNS option TLV scanner with random records and flow control.
`timescale 1ns / 1ps

module edns_option_tlv_scanner_top_tb;
    import eots_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 8'hFF;

    typedef struct packed {
        logic        action;
        logic [15:0] record_length;
        logic [7:0]  data_byte;
    } scan_item_t;

    logic clk;
    logic rst_n;

    eots_item_if   item_ch ();
    eots_result_if res_ch ();
    eots_cfg_if    cfg_ch ();

    edns_option_tlv_scanner_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    scan_item_t record_items[$];
    res_t       scan_results_due[$];

    // Register mirror.
    logic [15:0] opt_match_code;
    logic        opt_match_all;
    logic [7:0]  opt_capacity;
    logic [13:0] opt_start_index;

    // Scan state mirror.
    phase_t      sc_phase;
    logic [1:0]  hdr_cnt;
    logic [15:0] code_acc;
    logic [15:0] len_acc;
    logic [15:0] rec_left;
    logic [15:0] val_left;
    logic [15:0] byte_pos;
    logic [13:0] opt_idx;
    logic [7:0]  rep_cnt;

    int fails;
    int queued;
    int src_gap;
    int sink_gap;
    int quiet_cycles;
    bit idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_fail(input string what);
        if (fails < 10)
            $display("%0t: %s", $realtime, what);
        fails++;
    endtask

    task automatic close_scan(input logic [1:0] st, input logic [13:0] resume);
        res_t r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        r.resume_index = resume;
        r.found_count = rep_cnt;
        r.last = 1'b1;
        scan_results_due.push_back(r);
        sc_phase = PH_DONE;
    endtask

    task automatic option_boundary();
        if (rec_left == 16'd0)
            close_scan(ST_SUCCESS, 14'd0);
        else if (rec_left < HEADER_BYTES)
            close_scan(ST_UNEXPECTED, 14'd0);
        else
        begin
            sc_phase = PH_HEADER;
            hdr_cnt = 2'd0;
            code_acc = 16'd0;
            len_acc = 16'd0;
        end
    endtask

    task automatic take_byte();
        if (rec_left > 16'd0)
            rec_left--;
        byte_pos++;
    endtask

    // Works out the results that one accepted item causes.
    task automatic advance_scan(input logic act, input logic [15:0] rlen, input logic [7:0] b);
        res_t r;
        bit   hit;
        if (act == ACT_START)
        begin
            rec_left = rlen;
            val_left = 16'd0;
            byte_pos = 16'd0;
            opt_idx = 14'd0;
            rep_cnt = 8'd0;
            option_boundary();
        end
        else if (sc_phase == PH_HEADER)
        begin
            if (hdr_cnt < 2)
                code_acc = {code_acc[7:0], b};
            else
                len_acc = {len_acc[7:0], b};
            take_byte();
            if (hdr_cnt < HEADER_BYTES - 1)
                hdr_cnt++;
            else
            begin
                hdr_cnt = 2'd0;
                hit = (code_acc == opt_match_code || opt_match_all) && opt_idx >= opt_start_index;
                if (len_acc > rec_left)
                    close_scan(ST_UNEXPECTED, 14'd0);
                else if (hit && rep_cnt >= opt_capacity)
                    close_scan(ST_MORE, opt_idx);
                else
                begin
                    if (hit)
                    begin
                        rep_cnt++;
                        r = '0;
                        r.kind = KIND_REPORT;
                        r.option_code = code_acc;
                        r.option_length = len_acc;
                        r.value_offset = byte_pos;
                        r.option_index = opt_idx;
                        r.found_count = rep_cnt;
                        scan_results_due.push_back(r);
                    end
                    if (len_acc == 16'd0)
                    begin
                        opt_idx++;
                        option_boundary();
                    end
                    else
                    begin
                        val_left = len_acc;
                        sc_phase = PH_VALUE;
                    end
                end
            end
        end
        else if (sc_phase == PH_VALUE)
        begin
            take_byte();
            if (val_left > 16'd0)
                val_left--;
            if (val_left == 16'd0)
            begin
                opt_idx++;
                option_boundary();
            end
        end
    endtask

    function automatic bit same_result(input res_t a, input res_t b);
        return a.kind === b.kind && a.status === b.status
            && a.option_code === b.option_code && a.option_length === b.option_length
            && a.value_offset === b.value_offset && a.option_index === b.option_index
            && a.resume_index === b.resume_index && a.found_count === b.found_count
            && a.last === b.last;
    endfunction

    task automatic show_result(input string tag, input res_t r);
        $display("  %s kind=%0d status=%0d code=%h len=%0d off=%0d idx=%0d",
                 tag, r.kind, r.status, r.option_code, r.option_length, r.value_offset,
                 r.option_index);
        $display("  %s resume=%0d found=%0d last=%0d",
                 tag, r.resume_index, r.found_count, r.last);
    endtask

    task automatic check_result(input res_t got);
        res_t due;
        if (scan_results_due.size() == 0)
        begin
            if (fails < 10)
                show_result("got", got);
            note_fail("result transfer with no result due");
        end
        else
        begin
            due = scan_results_due.pop_front();
            if (!same_result(due, got))
            begin
                if (fails < 10)
                begin
                    show_result("due", due);
                    show_result("got", got);
                end
                note_fail("result mismatch");
            end
        end
    endtask

    // Item driver.
    always @(posedge clk)
    begin
        scan_item_t nxt;
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (record_items.size() > 0)
            begin
                nxt = record_items.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.action <= nxt.action;
                item_ch.record_length <= nxt.record_length;
                item_ch.data_byte <= nxt.data_byte;
                if (idle_on && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 4);
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // Monitor, result stall pattern and watchdog.
    always @(posedge clk)
    begin
        res_t got;
        bit   moved;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            moved = 1'b0;
            if (item_ch.valid && item_ch.ready)
            begin
                advance_scan(item_ch.action, item_ch.record_length, item_ch.data_byte);
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.kind = res_ch.kind;
                got.status = res_ch.status;
                got.option_code = res_ch.option_code;
                got.option_length = res_ch.option_length;
                got.value_offset = res_ch.value_offset;
                got.option_index = res_ch.option_index;
                got.resume_index = res_ch.resume_index;
                got.found_count = res_ch.found_count;
                got.last = res_ch.last;
                check_result(got);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
                moved = 1'b1;

            if (sink_gap > 0)
            begin
                sink_gap--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 4);
            end

            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic push_start(input logic [15:0] rlen);
        scan_item_t it;
        it.action = ACT_START;
        it.record_length = rlen;
        it.data_byte = 8'($urandom_range(0, 255));
        record_items.push_back(it);
        queued++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        scan_item_t it;
        it.action = ACT_DATA;
        it.record_length = 16'($urandom_range(0, 65535));
        it.data_byte = b;
        record_items.push_back(it);
        queued++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_MATCH_CODE:  opt_match_code = val;
            CFG_MATCH_ALL:   opt_match_all = val[0];
            CFG_CAPACITY:    opt_capacity = val[7:0];
            CFG_START_INDEX: opt_start_index = val[13:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] code, input logic all,
                              input logic [7:0] cap, input logic [13:0] first);
        write_reg(CFG_MATCH_CODE, code);
        write_reg(CFG_MATCH_ALL, {15'd0, all});
        write_reg(CFG_CAPACITY, {8'd0, cap});
        write_reg(CFG_START_INDEX, {2'd0, first});
    endtask

    // Waits until every item is taken and every result has come, then lets the block settle.
    task automatic drain();
        do @(posedge clk);
        while (record_items.size() != 0 || item_ch.valid || scan_results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 3))
            0, 1: return opt_match_code;
            2: return 16'($urandom_range(0, 3) * 4 + 8);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic gen_record();
        logic [7:0]  rec[$];
        logic [15:0] code;
        int          olen;
        int          mode;
        int          declared;
        int          sel;
        repeat ($urandom_range(0, 5))
        begin
            code = pick_code();
            sel = $urandom_range(0, 15);
            if (sel < 4)
                olen = 0;
            else if (sel < 13)
                olen = $urandom_range(1, 6);
            else if (sel < 15)
                olen = $urandom_range(7, 40);
            else
                olen = $urandom_range(256, 300);
            rec.push_back(code[15:8]);
            rec.push_back(code[7:0]);
            rec.push_back(8'(olen >> 8));
            rec.push_back(8'(olen));
            repeat (olen) rec.push_back(8'($urandom_range(0, 255)));
        end

        mode = $urandom_range(0, 9);
        declared = rec.size();
        if (mode == 6)
        begin
            // A short tail where the next header should begin.
            repeat ($urandom_range(1, 3)) rec.push_back(8'($urandom_range(0, 255)));
            declared = rec.size();
        end
        else if (mode == 7 && rec.size() > 0)
            declared = $urandom_range(0, rec.size() - 1);
        else if (mode == 8)
        begin
            // The record claims more bytes than follow; the next start abandons it.
            if ($urandom_range(0, 1) == 0)
                declared = rec.size() + $urandom_range(1, 5);
            else
                declared = $urandom_range(rec.size() + 1, 65535);
        end
        else if (mode == 9)
        begin
            code = pick_code();
            rec.push_back(code[15:8]);
            rec.push_back(code[7:0]);
            rec.push_back(8'($urandom_range(0, 255)));
            rec.push_back(8'($urandom_range(0, 255)));
            declared = rec.size() + $urandom_range(0, 3);
        end
        if (declared > 65535)
            declared = 65535;

        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
        push_start(16'(declared));
        foreach (rec[i])
            push_byte(rec[i]);
    endtask

    // The last record of a phase may overrun the budget.
    task automatic run_phase(input int budget);
        int goal;
        goal = queued + budget;
        while (queued < goal)
            gen_record();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_START;
        item_ch.record_length = 16'd0;
        item_ch.data_byte = 8'd0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_MATCH_CODE;
        cfg_ch.data = '0;
        fails = 0;
        queued = 0;
        src_gap = 0;
        sink_gap = 0;
        idle_on = 1'b1;

        opt_match_code = 16'd0;
        opt_match_all = 1'b0;
        opt_capacity = 8'd1;
        opt_start_index = 14'd0;
        sc_phase = PH_IDLE;
        hdr_cnt = 2'd0;
        code_acc = 16'd0;
        len_acc = 16'd0;
        rec_left = 16'd0;
        val_left = 16'd0;
        byte_pos = 16'd0;
        opt_idx = 14'd0;
        rep_cnt = 8'd0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed records under the reset register values.
        push_start(16'd0);
        push_start(16'd3);
        push_byte(8'hAB);
        push_start(16'd4);
        repeat (4) push_byte(8'h00);
        push_start(16'd8);
        repeat (8) push_byte(8'h00);
        push_start(16'd7);
        repeat (4) push_byte(8'hFF);
        push_start(16'hFFFF);
        push_byte(8'h12);
        push_byte(8'h34);
        push_start(16'd0);
        drain();

        set_config(16'h000A, 1'b0, 8'd255, 14'd0);
        write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
        run_phase(70);
        set_config(16'hFFFF, 1'b1, 8'd0, 14'd0);
        run_phase(60);
        set_config(16'h0008, 1'b1, 8'd2, 14'd1);
        run_phase(70);
        set_config(16'h0000, 1'b0, 8'd3, 14'd16383);
        run_phase(60);
        set_config(16'($urandom_range(0, 65535)), 1'b1, 8'($urandom_range(1, 8)),
                   14'($urandom_range(0, 3)));
        run_phase(90);
        set_config(16'h000C, 1'b0, 8'd255, 14'd2);
        run_phase(70);

        // Full-rate stretch at the end of the run.
        idle_on = 1'b0;
        set_config(16'($urandom_range(2, 3) * 4), 1'($urandom_range(0, 1)),
                   8'($urandom_range(1, 4)), 14'd0);
        run_phase(80);

        if (scan_results_due.size() != 0)
            note_fail("results still due at end of run");
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/eots_pkg.sv
hdl/eots_ifs.sv
hdl/eots_cfg.sv
hdl/eots_core.sv
hdl/eots_fifo.sv
hdl/edns_option_tlv_scanner_top.sv
sim/edns_option_tlv_scanner_top_tb.sv
